@@ src/go_back_n_sender_assert.svh @@
// go_back_n_sender_assert.svh: assertion macros
`ifndef GO_BACK_N_SENDER_ASSERT_SVH
`define GO_BACK_N_SENDER_ASSERT_SVH
`ifndef SYNTHESIS
`define GBN_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define GBN_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define GBN_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define GBN_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

@@ src/gbn_pkg.sv @@
// ----------------------------------------------------------------------------
// gbn_pkg: shared types and constants of the go-back-n sender
// ----------------------------------------------------------------------------
package gbn_pkg;
   localparam logic [1:0] MODE_MSG = 2'd0;
   localparam logic [1:0] MODE_ACK = 2'd1;
   localparam logic [1:0] MODE_TMO = 2'd2;
   localparam logic [1:0] TMR_NONE = 2'd0;
   localparam logic [1:0] TMR_START = 2'd1;
   localparam logic [1:0] TMR_STOP = 2'd2;
   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_BADSUM = 2'd2;
   localparam logic [1:0] ST_OUTWIN = 2'd3;
   localparam logic [1:0] REG_WINDOW = 2'd0;
   localparam logic [1:0] REG_TIMEOUT = 2'd1;
   localparam int PAIRS = 10;

   typedef struct packed {
      logic [1:0]  mode;
      logic [63:0] payload_word0;
      logic [63:0] payload_word1;
      logic [31:0] payload_word2;
      logic [15:0] ack_seq_field;
      logic signed [15:0] ack_number;
      logic [15:0] ack_check_value;
   } req_type;

   typedef struct packed {
      logic        packet_valid;
      logic [11:0] seq_out;
      logic [15:0] check_out;
      logic [63:0] payload_out0;
      logic [63:0] payload_out1;
      logic [31:0] payload_out2;
      logic [1:0]  timer_command;
      logic [15:0] timer_length;
      logic [1:0]  status;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic        start;
      logic [15:0] seq;
      logic [15:0] ack;
   } sum_ctl_type;

   function automatic logic [7:0] byte_of(input logic [159:0] p, input logic [4:0] k);
      logic [7:0] b;
      b = p[159 - 8 * k -: 8];
      return b;
   endfunction
endpackage

@@ src/gbn_if.sv @@
// ----------------------------------------------------------------------------
// gbn_req_if / gbn_rsp_if: valid-ready channels
// ----------------------------------------------------------------------------
interface gbn_req_if;
   logic              valid;
   logic              ready;
   gbn_pkg::req_type  payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface gbn_rsp_if;
   logic              valid;
   logic              ready;
   gbn_pkg::rsp_type  payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ src/gbn_checksum.sv @@
// ----------------------------------------------------------------------------
// gbn_checksum: serial checksum, one byte pair per cycle
// Walks the 20 payload bytes as 10 pairs, stops at the first zero byte,
// then adds seq and ack and inverts.
// ----------------------------------------------------------------------------
module gbn_checksum (
   input  logic                  clock,
   input  logic                  reset,
   input  gbn_pkg::sum_ctl_type  ctl,
   input  logic [159:0]          payload,
   output logic                  done,
   output logic [15:0]           sum
);
   logic [3:0]   idx_ff, idx_in;
   logic         busy_ff, busy_in;
   logic         fin_ff, fin_in;
   logic [15:0]  acc_ff, acc_in;
   logic [159:0] pay_ff, pay_in;
   logic [15:0]  seq_ff, seq_in, ack_ff, ack_in;
   logic [7:0]   hi, lo;

   always_comb begin
      hi = gbn_pkg::byte_of(pay_ff, {idx_ff, 1'b0});
      lo = gbn_pkg::byte_of(pay_ff, {idx_ff, 1'b1});
      idx_in = idx_ff;
      busy_in = busy_ff;
      fin_in = 1'b0;
      acc_in = acc_ff;
      pay_in = pay_ff;
      seq_in = seq_ff;
      ack_in = ack_ff;
      if (ctl.start) begin
         busy_in = 1'b1;
         idx_in = '0;
         acc_in = '0;
         pay_in = payload;
         seq_in = ctl.seq;
         ack_in = ctl.ack;
      end else if (busy_ff) begin
         if (hi == 8'd0 || lo == 8'd0 || idx_ff == 4'(gbn_pkg::PAIRS - 1)) begin
            if (hi != 8'd0 && lo != 8'd0) acc_in = acc_ff + {hi, lo};
            busy_in = 1'b0;
            fin_in = 1'b1;
         end else begin
            acc_in = acc_ff + {hi, lo};
            idx_in = idx_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff <= fin_in;
      end
      idx_ff <= idx_in;
      acc_ff <= acc_in;
      pay_ff <= pay_in;
      seq_ff <= seq_in;
      ack_ff <= ack_in;
   end

   assign done = fin_ff;
   assign sum = ~(acc_ff + seq_ff + ack_ff);
endmodule

@@ src/gbn_store.sv @@
// ----------------------------------------------------------------------------
// gbn_store: packet store, one write plus one registered read of the same address per cycle
// ----------------------------------------------------------------------------
module gbn_store #(
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [175:0]             wdata,
   output logic [175:0]             rdata
);
   logic [175:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata <= mem[addr];
   end
endmodule

@@ src/go_back_n_sender.sv @@
// ----------------------------------------------------------------------------
// go_back_n_sender: go-back-n ARQ sender
// Takes message, ACK and timeout items and emits packets and timer commands.
// ----------------------------------------------------------------------------
// Message and ACK items pass through the checksum unit, one byte pair per
// cycle until the first zero byte; a message is then written to the store
// and, if the window allows, the next packet read back, both via its single
// port. A timeout emits one result per outstanding packet, each read through
// S_RD and S_RDW before the output handshake, or a timer start if none is
// outstanding. No item is taken until every result of the previous one is
// delivered. The store has no reset; unwritten entries are never read.
module go_back_n_sender #(
   parameter int BUFFER_DEPTH = 4096,
   parameter int MAX_WINDOW = 64
) (
   input  logic         clock,
   input  logic         reset,
   gbn_req_if.sink      req,
   gbn_rsp_if.source    rsp,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [15:0]  csr_wdata
);
   `include "go_back_n_sender_assert.svh"

   localparam int AW = $clog2(BUFFER_DEPTH);
   localparam int CW = AW + 1;
   localparam int NBW = (CW > 16) ? CW + 1 : 17;

   typedef enum logic [7:0] {
      S_IDLE = 8'b00000001,
      S_SUM  = 8'b00000010,
      S_MSG  = 8'b00000100,
      S_RD   = 8'b00001000,
      S_RDW  = 8'b00010000,
      S_EMIT = 8'b00100000,
      S_OUT  = 8'b01000000,
      S_TMO  = 8'b10000000
   } state_type;

   state_type        st_ff, st_in;
   logic [6:0]       win_ff, win_in;
   logic [15:0]      tmo_ff, tmo_in;
   logic [CW-1:0]    base_ff, base_in, nts_ff, nts_in, cnt_ff, cnt_in, rp_ff, rp_in;
   gbn_pkg::req_type item_ff, item_in;
   gbn_pkg::rsp_type out_ff, out_in;
   logic             first_ff, first_in;
   logic             we;
   logic [AW-1:0]    addr;
   logic [175:0]     wdata, rdata;
   gbn_pkg::sum_ctl_type sctl;
   logic             sdone;
   logic [15:0]      ssum;
   logic [6:0]       ewin;
   logic signed [NBW-1:0] nb;

   gbn_checksum u_sum (
      .clock(clock), .reset(reset), .ctl(sctl),
      .payload({item_in.payload_word0, item_in.payload_word1, item_in.payload_word2}),
      .done(sdone), .sum(ssum)
   );

   gbn_store #(.DEPTH(BUFFER_DEPTH)) u_store (
      .clock(clock), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
   );

   assign ewin = (win_ff == 7'd0) ? 7'd1 :
                 (win_ff > 7'(MAX_WINDOW)) ? 7'(MAX_WINDOW) : win_ff;
   assign nb = NBW'($signed(item_ff.ack_number)) + NBW'(1);
   assign req.ready = (st_ff == S_IDLE);
   assign rsp.valid = (st_ff == S_OUT);
   assign rsp.payload = out_ff;

   always_comb begin
      st_in = st_ff;
      win_in = win_ff;
      tmo_in = tmo_ff;
      base_in = base_ff;
      nts_in = nts_ff;
      cnt_in = cnt_ff;
      rp_in = rp_ff;
      item_in = item_ff;
      out_in = out_ff;
      first_in = first_ff;
      we = 1'b0;
      addr = rp_ff[AW-1:0];
      wdata = {ssum, item_ff.payload_word0, item_ff.payload_word1, item_ff.payload_word2};
      sctl = '0;
      if (csr_we) begin
         if (csr_index == gbn_pkg::REG_WINDOW) win_in = csr_wdata[6:0];
         if (csr_index == gbn_pkg::REG_TIMEOUT) tmo_in = csr_wdata;
      end
      case (st_ff)
         S_IDLE: begin
            if (req.valid) begin
               item_in = req.payload;
               out_in = '0;
               out_in.last = 1'b1;
               if (req.payload.mode == gbn_pkg::MODE_MSG) begin
                  sctl.start = 1'b1;
                  sctl.seq = 16'(cnt_ff);
                  st_in = S_SUM;
               end else if (req.payload.mode == gbn_pkg::MODE_ACK) begin
                  sctl.start = 1'b1;
                  sctl.seq = req.payload.ack_seq_field;
                  sctl.ack = req.payload.ack_number;
                  st_in = S_SUM;
               end else if (req.payload.mode == gbn_pkg::MODE_TMO) begin
                  rp_in = base_ff;
                  first_in = 1'b1;
                  st_in = S_TMO;
               end
            end
         end
         S_SUM: begin
            if (sdone) begin
               if (item_ff.mode == gbn_pkg::MODE_MSG) st_in = S_MSG;
               else begin
                  if (ssum != item_ff.ack_check_value) out_in.status = gbn_pkg::ST_BADSUM;
                  else if (nb < $signed(NBW'(base_ff)) || nb > $signed(NBW'(nts_ff)))
                     out_in.status = gbn_pkg::ST_OUTWIN;
                  else begin
                     base_in = nb[CW-1:0];
                     if (nb[CW-1:0] == nts_ff) out_in.timer_command = gbn_pkg::TMR_STOP;
                  end
                  st_in = S_OUT;
               end
            end
         end
         S_MSG: begin
            if (cnt_ff >= CW'(BUFFER_DEPTH)) out_in.status = gbn_pkg::ST_FULL;
            else begin
               we = 1'b1;
               addr = cnt_ff[AW-1:0];
               cnt_in = cnt_ff + CW'(1);
            end
            rp_in = nts_ff;
            first_in = (base_ff == nts_ff);
            if (nts_ff < cnt_in && nts_ff < base_ff + CW'(ewin)) begin
               nts_in = nts_ff + CW'(1);
               st_in = S_RD;
            end else st_in = S_OUT;
         end
         S_TMO: begin
            if (rp_ff >= nts_ff) begin
               out_in.timer_command = gbn_pkg::TMR_START;
               out_in.timer_length = tmo_ff;
               st_in = S_OUT;
            end else st_in = S_RD;
         end
         S_RD: begin
            st_in = S_RDW;
         end
         S_RDW: begin
            out_in.packet_valid = 1'b1;
            out_in.seq_out = 12'(rp_ff);
            {out_in.check_out, out_in.payload_out0, out_in.payload_out1,
             out_in.payload_out2} = rdata;
            if (first_ff) begin
               out_in.timer_command = gbn_pkg::TMR_START;
               out_in.timer_length = tmo_ff;
            end
            if (item_ff.mode == gbn_pkg::MODE_TMO)
               out_in.last = (rp_ff + CW'(1) >= nts_ff);
            st_in = S_OUT;
         end
         S_OUT: begin
            if (rsp.ready) begin
               if (out_ff.last) st_in = S_IDLE;
               else begin
                  rp_in = rp_ff + CW'(1);
                  first_in = 1'b0;
                  out_in = '0;
                  st_in = S_RD;
               end
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         win_ff <= 7'd8;
         tmo_ff <= 16'd20;
         base_ff <= '0;
         nts_ff <= '0;
         cnt_ff <= '0;
         rp_ff <= '0;
      end else begin
         st_ff <= st_in;
         win_ff <= win_in;
         tmo_ff <= tmo_in;
         base_ff <= base_in;
         nts_ff <= nts_in;
         cnt_ff <= cnt_in;
         rp_ff <= rp_in;
      end
      item_ff <= item_in;
      out_ff <= out_in;
      first_ff <= first_in;
   end

   `GBN_ASSERT_IMP(a_base_le_nts, clock, reset, 1'b1, base_ff <= nts_ff, "base beyond next")
   `GBN_ASSERT_IMP(a_nts_le_cnt, clock, reset, 1'b1, nts_ff <= cnt_ff, "next beyond count")
   `GBN_ASSERT_IMP(a_busy_not_ready, clock, reset, rsp.valid, !req.ready, "ready while busy")
   `GBN_ASSERT_NXT(a_out_hold, clock, reset, rsp.valid && !rsp.ready, rsp.valid, "result lost")
endmodule

@@ tb/sv/go_back_n_sender_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// go_back_n_sender_tb: self-checking bench for the go-back-n sender
// Drives messages, ACKs and timer expiries with random gaps and output stalls,
// predicts every packet and timer command from a model of the send window
// and its store, and compares results field by field in order.
// ----------------------------------------------------------------------------
module go_back_n_sender_tb;

   localparam int DEPTH = 4096;
   localparam int WIN_MAX = 64;
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int SETTLE = 40;
   localparam int STALL_LIMIT = 3000;

   typedef enum {K_RAW, K_ACK_IN, K_ACK_OUT, K_CFG, K_DRAIN} stim_kind_type;

   typedef struct {
      stim_kind_type     kind;
      gbn_pkg::req_type  item;
      bit                burst;
      logic [1:0]        idx;
      logic [15:0]       data;
   } stim_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [1:0] csr_index;
   logic [15:0] csr_wdata;

   gbn_req_if req_if ();
   gbn_rsp_if rsp_if ();

   go_back_n_sender dut (
      .clock(clock), .reset(reset), .req(req_if), .rsp(rsp_if),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // window model
   logic [6:0]  win_reg;
   logic [15:0] tmo_reg;
   int          base_seq, next_seq, stored;
   logic [63:0] keep_lo [DEPTH];
   logic [63:0] keep_mid [DEPTH];
   logic [31:0] keep_hi [DEPTH];
   logic [15:0] keep_sum [DEPTH];

   stim_type          stim_q[$];
   gbn_pkg::rsp_type  awaited_rsp[$];
   int                errors = 0;
   int                gap, stall, idle_run, quiet_cnt, watch;
   bit                rsp_quiet;

   initial clock = 1'b0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [15:0] pkt_sum(input logic [159:0] p, input logic [15:0] seq,
                                           input logic [15:0] ack);
      int len;
      logic [15:0] s;
      len = 0;
      while (len < 20 && p[159 - 8 * len -: 8] != 8'd0) len++;
      s = 16'd0;
      for (int k = 0; k + 1 < len; k += 2) s += p[159 - 8 * k -: 16];
      s += seq;
      s += ack;
      return ~s;
   endfunction

   function automatic int win_eff();
      if (win_reg == 0) return 1;
      if (win_reg > WIN_MAX) return WIN_MAX;
      return win_reg;
   endfunction

   function automatic void load_packet(inout gbn_pkg::rsp_type r, input int i);
      r.packet_valid = 1'b1;
      r.seq_out = i[11:0];
      r.check_out = keep_sum[i];
      r.payload_out0 = keep_lo[i];
      r.payload_out1 = keep_mid[i];
      r.payload_out2 = keep_hi[i];
   endfunction

   function automatic void apply_item(input gbn_pkg::req_type it);
      gbn_pkg::rsp_type r;
      int nb;
      r = '0;
      case (it.mode)
         gbn_pkg::MODE_MSG: begin
            if (stored >= DEPTH) r.status = gbn_pkg::ST_FULL;
            else begin
               keep_lo[stored] = it.payload_word0;
               keep_mid[stored] = it.payload_word1;
               keep_hi[stored] = it.payload_word2;
               keep_sum[stored] = pkt_sum({it.payload_word0, it.payload_word1,
                  it.payload_word2}, stored[15:0], 16'd0);
               stored++;
            end
            if (next_seq < stored && next_seq < base_seq + win_eff()) begin
               load_packet(r, next_seq);
               if (base_seq == next_seq) begin
                  r.timer_command = gbn_pkg::TMR_START;
                  r.timer_length = tmo_reg;
               end
               next_seq++;
            end
            r.last = 1'b1;
            awaited_rsp.push_back(r);
         end
         gbn_pkg::MODE_ACK: begin
            nb = int'(it.ack_number) + 1;
            if (pkt_sum({it.payload_word0, it.payload_word1, it.payload_word2},
                        it.ack_seq_field, it.ack_number) != it.ack_check_value)
               r.status = gbn_pkg::ST_BADSUM;
            else if (nb < base_seq || nb > next_seq) r.status = gbn_pkg::ST_OUTWIN;
            else begin
               base_seq = nb;
               if (base_seq == next_seq) r.timer_command = gbn_pkg::TMR_STOP;
            end
            r.last = 1'b1;
            awaited_rsp.push_back(r);
         end
         gbn_pkg::MODE_TMO: begin
            if (base_seq >= next_seq) begin
               r.timer_command = gbn_pkg::TMR_START;
               r.timer_length = tmo_reg;
               r.last = 1'b1;
               awaited_rsp.push_back(r);
            end else begin
               for (int i = base_seq; i < next_seq && i < base_seq + WIN_MAX; i++) begin
                  r = '0;
                  load_packet(r, i);
                  if (i == base_seq) begin
                     r.timer_command = gbn_pkg::TMR_START;
                     r.timer_length = tmo_reg;
                  end
                  r.last = (i == next_seq - 1) || (i == base_seq + WIN_MAX - 1);
                  awaited_rsp.push_back(r);
               end
            end
         end
         default: ;
      endcase
   endfunction

   function automatic logic [159:0] rand_bytes();
      logic [159:0] p;
      for (int k = 0; k < 20; k++)
         p[159 - 8 * k -: 8] = ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
      return p;
   endfunction

   function automatic gbn_pkg::req_type make_req(input logic [1:0] mode,
                                                 input logic [159:0] p);
      gbn_pkg::req_type it;
      it.mode = mode;
      {it.payload_word0, it.payload_word1, it.payload_word2} = p;
      it.ack_seq_field = 16'($urandom);
      it.ack_number = 16'($urandom);
      it.ack_check_value = 16'($urandom);
      return it;
   endfunction

   function automatic void queue_item(input stim_kind_type kind, input gbn_pkg::req_type it,
                                      input bit burst);
      stim_type s;
      s.kind = kind;
      s.item = it;
      s.burst = burst;
      s.idx = gbn_pkg::REG_WINDOW;
      s.data = '0;
      stim_q.push_back(s);
   endfunction

   function automatic void queue_cfg(input logic [6:0] win, input logic [15:0] tmo);
      stim_type s;
      s.kind = K_DRAIN;
      s.burst = 1'b0;
      s.item = '0;
      stim_q.push_back(s);
      s.kind = K_CFG;
      s.idx = gbn_pkg::REG_WINDOW;
      s.data = {9'd0, win};
      stim_q.push_back(s);
      s.idx = gbn_pkg::REG_TIMEOUT;
      s.data = tmo;
      stim_q.push_back(s);
   endfunction

   // resolve ACK contents against the window as it stands when the item is offered
   function automatic gbn_pkg::req_type shape_ack(input stim_type s);
      gbn_pkg::req_type it;
      int n;
      it = s.item;
      if (s.kind == K_ACK_IN)
         n = base_seq - 1 + $urandom_range(0, next_seq - base_seq);
      else case ($urandom_range(0, 2))
         0: n = next_seq + 1 + $urandom_range(0, 3);
         1: n = (base_seq >= 2) ? base_seq - 2 : next_seq + 1;
         default: n = $urandom_range(0, 65535);
      endcase
      it.ack_number = 16'(n);
      it.ack_check_value = pkt_sum({it.payload_word0, it.payload_word1, it.payload_word2},
                                   it.ack_seq_field, it.ack_number);
      return it;
   endfunction

   // stimulus driver
   always @(posedge clock) begin
      logic valid_n;
      logic we_n;
      stim_type s;
      if (reset) begin
         req_if.valid <= 1'b0;
         csr_we <= 1'b0;
         gap = 0;
         idle_run = 0;
      end else begin
         valid_n = req_if.valid;
         we_n = 1'b0;
         if (req_if.valid && req_if.ready) begin
            apply_item(req_if.payload);
            valid_n = 1'b0;
         end
         if (!valid_n && awaited_rsp.size() == 0 && !req_if.valid) idle_run++;
         else idle_run = 0;
         if (!valid_n && stim_q.size() > 0) begin
            s = stim_q[0];
            if (s.kind == K_DRAIN) begin
               if (awaited_rsp.size() == 0) void'(stim_q.pop_front());
            end else if (s.kind == K_CFG) begin
               if (idle_run >= 32) begin
                  we_n = 1'b1;
                  csr_index <= s.idx;
                  csr_wdata <= s.data;
                  if (s.idx == gbn_pkg::REG_WINDOW) win_reg = s.data[6:0];
                  else tmo_reg = s.data;
                  void'(stim_q.pop_front());
               end
            end else if (gap > 0) begin
               gap--;
            end else begin
               req_if.payload <= (s.kind == K_RAW) ? s.item : shape_ack(s);
               valid_n = 1'b1;
               gap = s.burst ? 0 : $urandom_range(0, 10);
               void'(stim_q.pop_front());
            end
         end
         req_if.valid <= valid_n;
         csr_we <= we_n;
      end
   end

   // result monitor
   always @(posedge clock) begin
      gbn_pkg::rsp_type exp_r;
      gbn_pkg::rsp_type got;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall = 0;
         quiet_cnt = 0;
         rsp_quiet = 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            got = rsp_if.payload;
            if (awaited_rsp.size() == 0) begin
               errors++;
               $display("%0t: unexpected result expected none actual %h", $time, got);
            end else begin
               exp_r = awaited_rsp.pop_front();
               if (got.packet_valid !== exp_r.packet_valid || got.seq_out !== exp_r.seq_out
                   || got.check_out !== exp_r.check_out
                   || got.payload_out0 !== exp_r.payload_out0
                   || got.payload_out1 !== exp_r.payload_out1
                   || got.payload_out2 !== exp_r.payload_out2
                   || got.timer_command !== exp_r.timer_command
                   || got.timer_length !== exp_r.timer_length
                   || got.status !== exp_r.status || got.last !== exp_r.last) begin
                  errors++;
                  $display("%0t: result mismatch expected %h actual %h", $time, exp_r, got);
               end
            end
            quiet_cnt++;
            if (quiet_cnt % 64 == 0) rsp_quiet = !rsp_quiet;
            stall = rsp_quiet ? 0 : $urandom_range(0, 10);
         end else if (stall > 0) begin
            stall--;
         end
         rsp_if.ready <= (stall == 0);
      end
   end

   // watchdog on handshakes
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || csr_we)
         watch <= 0;
      else if (watch >= STALL_LIMIT) begin
         $display("go_back_n_sender verification failed");
         $finish;
      end else
         watch <= watch + 1;
   end

   initial begin
      logic [159:0] p;
      gbn_pkg::req_type it;
      int r;
      bit burst;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      rsp_if.ready = 1'b0;
      csr_we = 1'b0;
      csr_index = gbn_pkg::REG_WINDOW;
      csr_wdata = '0;
      win_reg = 7'd8;
      tmo_reg = 16'd20;
      base_seq = 0;
      next_seq = 0;
      stored = 0;

      // directed
      queue_item(K_RAW, make_req(gbn_pkg::MODE_TMO, '0), 0);
      queue_item(K_RAW, make_req(gbn_pkg::MODE_MSG, {20{8'hFF}}), 0);
      queue_item(K_RAW, make_req(gbn_pkg::MODE_MSG, '0), 0);
      queue_item(K_RAW, make_req(gbn_pkg::MODE_MSG,
                 {8'h12, 8'h34, 8'h56, 8'h00, {16{8'hAB}}}), 0);
      queue_item(K_RAW, make_req(gbn_pkg::MODE_MSG,
                 {8'h80, 8'h01, 8'h7F, 8'h00, {16{8'h00}}}), 0);
      queue_item(K_RAW, make_req(gbn_pkg::MODE_MSG, {{19{8'h01}}, 8'h00}), 0);
      queue_item(K_RAW, make_req(gbn_pkg::MODE_TMO, '0), 0);
      queue_item(K_RAW, make_req(gbn_pkg::MODE_ACK, {20{8'h5A}}), 0);
      queue_item(K_ACK_OUT, make_req(gbn_pkg::MODE_ACK, {20{8'h00}}), 0);
      queue_item(K_ACK_IN, make_req(gbn_pkg::MODE_ACK, {20{8'hFF}}), 0);
      queue_item(K_RAW, make_req(MODE_UNUSED, {20{8'hFF}}), 0);
      for (int i = 0; i < 10; i++)
         queue_item(K_RAW, make_req(gbn_pkg::MODE_MSG, rand_bytes()), 0);
      queue_item(K_RAW, make_req(gbn_pkg::MODE_TMO, '0), 0);
      queue_item(K_ACK_IN, make_req(gbn_pkg::MODE_ACK, rand_bytes()), 0);
      it = make_req(gbn_pkg::MODE_ACK, rand_bytes());
      stim_q.push_back('{K_ACK_IN, it, 1'b0, gbn_pkg::REG_WINDOW, 16'd0});

      // random phases over several register settings
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: ;
            1: queue_cfg(7'd1, 16'd0);
            2: queue_cfg(7'd0, 16'hFFFF);
            3: queue_cfg(7'h7F, 16'd1);
            4: queue_cfg(7'd64, 16'($urandom));
            default: queue_cfg(7'($urandom_range(1, 64)), 16'($urandom));
         endcase
         for (int i = 0; i < 72; i++) begin
            burst = ((i / 20) % 3) == 2;
            r = $urandom_range(0, 99);
            p = rand_bytes();
            if (r < 45) queue_item(K_RAW, make_req(gbn_pkg::MODE_MSG, p), burst);
            else if (r < 75) queue_item(K_ACK_IN, make_req(gbn_pkg::MODE_ACK, p), burst);
            else if (r < 83) queue_item(K_ACK_OUT, make_req(gbn_pkg::MODE_ACK, p), burst);
            else if (r < 88) queue_item(K_RAW, make_req(gbn_pkg::MODE_ACK, p), burst);
            else if (r < 98) queue_item(K_RAW, make_req(gbn_pkg::MODE_TMO, p), burst);
            else queue_item(K_RAW, make_req(MODE_UNUSED, p), burst);
         end
      end

      // wide window, mixed tail
      queue_cfg(7'd64, 16'd20);
      for (int i = 0; i < 30; i++) begin
         p = rand_bytes();
         r = $urandom_range(0, 3);
         if (r == 0) queue_item(K_RAW, make_req(gbn_pkg::MODE_MSG, p), 0);
         else if (r == 1) queue_item(K_ACK_IN, make_req(gbn_pkg::MODE_ACK, p), 0);
         else queue_item(K_RAW, make_req(gbn_pkg::MODE_TMO, p), 0);
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (stim_q.size() > 0 || req_if.valid || awaited_rsp.size() > 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (errors == 0 && awaited_rsp.size() == 0)
         $display("go_back_n_sender verification clean");
      else
         $display("go_back_n_sender verification failed");
      $finish;
   end
endmodule
